[sv/ptl_pkg.sv]
// ----------------------------------------------------------------------------
// ptl_pkg
// shared types and constants of the paged translation block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ptl_pkg;

	localparam int DEF_PROCESSES = 4;
	localparam int DEF_FRAMES    = 256;
	localparam int DEF_PAGES     = 65536;

	localparam int PROC_W  = 2;
	localparam int PAGE_W  = 16;
	localparam int OFS_W   = 16;
	localparam int REF_W   = 8;
	localparam int FIDX_W  = 8;
	localparam int PSLOTS  = 4;

	localparam logic [REF_W-1:0] REF_MAX      = 8'd255;
	localparam logic [15:0]      TOTAL_MAX    = 16'hFFFF;
	localparam logic [7:0]       PERIOD_RESET = 8'd5;

	typedef enum logic {OP_ACCESS = 1'b0, OP_EXIT = 1'b1} op_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [PROC_W-1:0] owner;
		logic              busy;
		logic              dirty;
		logic [REF_W-1:0]  refs;
	} fe_t;

	typedef struct packed {
		logic              free_found;
		logic [FIDX_W-1:0] free_idx;
		logic [FIDX_W-1:0] best_idx;
		fe_t               best;
	} vic_t;

endpackage
`default_nettype wire

[sv/ptl_ram.sv]
// ----------------------------------------------------------------------------
// ptl_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[sv/ptl_victim.sv]
// ----------------------------------------------------------------------------
// ptl_victim
// tracks the first free frame and the lfu victim over a frame scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptl_victim (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          dv,
	input  wire logic [ptl_pkg::FIDX_W-1:0]    idx,
	input  wire ptl_pkg::fe_t                  ent,
	input  wire logic [ptl_pkg::PROC_W-1:0]    proc,
	input  wire logic [ptl_pkg::PSLOTS-1:0]    dead,
	output ptl_pkg::vic_t                      vic
);
	import ptl_pkg::*;

	logic              dead_hit_q;
	logic              free_found_q;
	logic [FIDX_W-1:0] free_idx_q;
	logic [FIDX_W-1:0] best_idx_q;
	fe_t               best_q;
	logic              better;

	always_comb begin
		vic.free_found = free_found_q;
		vic.free_idx   = free_idx_q;
		vic.best_idx   = best_idx_q;
		vic.best       = best_q;
	end

	always_comb begin
		better = (ent.refs < best_q.refs) ||
			(ent.refs == best_q.refs && !ent.dirty && best_q.dirty) ||
			(ent.refs == best_q.refs && ent.dirty == best_q.dirty && ent.owner == proc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_found_q <= 1'b0;
			dead_hit_q   <= 1'b0;
		end else if (start) begin
			free_found_q <= 1'b0;
			dead_hit_q   <= 1'b0;
		end else if (dv) begin
			if (!free_found_q && !ent.busy) begin
				free_found_q <= 1'b1;
			end
			if (!dead_hit_q && dead[ent.owner]) begin
				dead_hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dv) begin
			if (!free_found_q && !ent.busy) begin
				free_idx_q <= idx;
			end
			if (!dead_hit_q && (dead[ent.owner] || idx == '0 || better)) begin
				best_q     <= ent;
				best_idx_q <= idx;
			end
		end
	end

endmodule
`default_nettype wire

[sv/paged_translation_lfu_replace.sv]
// ----------------------------------------------------------------------------
// paged_translation_lfu_replace
// per-process page table translation with lfu frame replacement
// ----------------------------------------------------------------------------
// hit: page read, check, frame update, finish; fault and process exit: a scan
// of every frame (one frame read per cycle through the frame table port).
// one word in work at a time; a finished result waits in the output register
// reset: a clearing pass over max(PROCESSES*PAGES, FRAMES) entries (262144 by
// default) sweeps both tables; no word is taken until it ends
`timescale 1ns / 1ps
`default_nettype none
module paged_translation_lfu_replace #(
	parameter int PROCESSES = ptl_pkg::DEF_PROCESSES,
	parameter int FRAMES    = ptl_pkg::DEF_FRAMES,
	parameter int PAGES     = ptl_pkg::DEF_PAGES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// process[1:0], address[33:2], is_write[34], zero fill
	input  wire logic [39:0] s_tdata,
	// operation
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// physical_address[23:0], page_fault[24], evicted[25], evicted_process[27:26],
	// evicted_page[43:28], write_back[44], fault_total[60:45],
	// write_back_total[76:61], zero fill
	output logic [79:0]      m_tdata
);
	import ptl_pkg::*;

	localparam int FW     = $clog2(FRAMES);
	localparam int PDEPTH = PROCESSES * PAGES;
	localparam int PW     = $clog2(PDEPTH);
	localparam int INIT_N = (PDEPTH > FRAMES) ? PDEPTH : FRAMES;
	localparam int IW     = $clog2(INIT_N);

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_PRD, ST_PCHK, ST_HIT, ST_SCAN, ST_SLAST,
		ST_SEL, ST_ALLOC, ST_FIN, ST_EXS, ST_EXL, ST_DONE
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     init_q;
	logic [FW-1:0]     cnt_q;
	logic [FW-1:0]     f_q;
	logic [PROC_W-1:0] proc_q;
	logic [PAGE_W-1:0] page_q;
	logic [OFS_W-1:0]  off_q;
	logic              wr_q;
	logic              acc_q;
	logic              fault_q;
	logic              ev_q;
	logic [PROC_W-1:0] evp_q;
	logic [PAGE_W-1:0] evg_q;
	logic              wb_q;
	logic [7:0]        acc_cnt_q;
	logic [15:0]       faults_q;
	logic [15:0]       wbt_q;
	logic [7:0]        period_q;
	logic [PSLOTS-1:0] dead_q;
	logic [FRAMES-1:0] stale_q;
	logic              v_s1;
	logic [FW-1:0]     idx_s1;

	logic          pm_we;
	logic [PW-1:0] pm_waddr;
	logic [FW:0]   pm_wdata;
	logic [FW:0]   pm_rdata;
	logic          fm_we;
	logic [FW-1:0] fm_waddr;
	fe_t           fm_wdata;
	logic [FW-1:0] fm_raddr;
	fe_t           fm_rdata;
	fe_t           scan_ent;
	fe_t           hit_ent;
	vic_t          vic;
	logic [FW-1:0] sel_f;
	logic          ex_hit;
	logic          accept;
	logic [PROC_W-1:0] in_proc;
	logic [PAGE_W-1:0] in_page;
	logic          proc_ok;
	logic          page_ok;
	logic [8:0]    next9;
	logic [8:0]    lim9;

	function automatic logic [PW-1:0] ent(input logic [PROC_W-1:0] p, input logic [PAGE_W-1:0] g);
		return PW'(PW'(p) * PW'(PAGES) + PW'(g));
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_proc  = s_tdata[1:0];
	assign in_page  = s_tdata[33:18];
	assign proc_ok  = 32'(in_proc) < 32'(PROCESSES);
	assign page_ok  = 32'(in_page) < 32'(PAGES);
	assign next9    = {1'b0, acc_cnt_q} + 9'd1;
	assign lim9     = (period_q == 8'd0) ? 9'd256 : {1'b0, period_q};
	assign sel_f    = vic.free_found ? vic.free_idx[FW-1:0] : vic.best_idx[FW-1:0];
	assign ex_hit   = v_s1 && (state_q == ST_EXS || state_q == ST_EXL) &&
		fm_rdata.busy && fm_rdata.owner == proc_q;

	always_comb begin
		scan_ent = fm_rdata;
		if (stale_q[idx_s1]) begin
			scan_ent.refs = '0;
		end
		hit_ent = fm_rdata;
		if (stale_q[f_q]) begin
			hit_ent.refs = '0;
		end
		hit_ent.dirty = hit_ent.dirty | wr_q;
		if (hit_ent.refs != REF_MAX) begin
			hit_ent.refs = hit_ent.refs + 8'd1;
		end
	end

	always_comb begin
		pm_we    = 1'b0;
		pm_waddr = ent(proc_q, page_q);
		pm_wdata = '0;
		fm_we    = 1'b0;
		fm_waddr = f_q;
		fm_wdata = fm_rdata;
		fm_raddr = cnt_q;
		case (state_q)
			ST_INIT: begin
				pm_we    = {1'b0, init_q} < (IW+1)'(PDEPTH);
				pm_waddr = init_q[PW-1:0];
				fm_we    = {1'b0, init_q} < (IW+1)'(FRAMES);
				fm_waddr = init_q[FW-1:0];
				fm_wdata = '0;
			end
			ST_PCHK: begin
				fm_raddr = pm_rdata[FW-1:0];
			end
			ST_HIT: begin
				fm_we    = 1'b1;
				fm_wdata = hit_ent;
			end
			ST_SEL: begin
				pm_we    = !vic.free_found;
				pm_waddr = ent(vic.best.owner, vic.best.page);
				fm_we    = 1'b1;
				fm_waddr = sel_f;
				fm_wdata = '{page: page_q, owner: proc_q, busy: 1'b1, dirty: wr_q, refs: 8'd1};
			end
			ST_ALLOC: begin
				pm_we    = 1'b1;
				pm_wdata = {1'b1, f_q};
			end
			ST_EXS, ST_EXL: begin
				pm_we         = ex_hit;
				pm_waddr      = ent(fm_rdata.owner, fm_rdata.page);
				fm_we         = ex_hit;
				fm_waddr      = idx_s1;
				fm_wdata.busy = 1'b0;
			end
			default: begin
			end
		endcase
	end

	ptl_ram #(.WIDTH(FW + 1), .DEPTH(PDEPTH)) u_page_ram (
		.clk   (clk),
		.we    (pm_we),
		.waddr (pm_waddr),
		.wdata (pm_wdata),
		.raddr (ent(proc_q, page_q)),
		.rdata (pm_rdata)
	);

	ptl_ram #(.WIDTH($bits(fe_t)), .DEPTH(FRAMES)) u_frame_ram (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	ptl_victim u_victim (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_PCHK),
		.dv     (v_s1 && (state_q == ST_SCAN || state_q == ST_SLAST)),
		.idx    (FIDX_W'(idx_s1)),
		.ent    (scan_ent),
		.proc   (proc_q),
		.dead   (dead_q),
		.vic    (vic)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_wen) begin
			period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			idx_s1 <= '0;
		end else begin
			v_s1   <= (state_q == ST_SCAN || state_q == ST_EXS);
			idx_s1 <= cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_q <= '0;
		end else if (state_q == ST_FIN && next9 >= lim9) begin
			stale_q <= '1;
		end else if (state_q == ST_HIT || state_q == ST_ALLOC) begin
			stale_q[f_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			init_q    <= '0;
			cnt_q     <= '0;
			acc_cnt_q <= '0;
			faults_q  <= '0;
			wbt_q     <= '0;
			dead_q    <= '0;
			m_tvalid  <= 1'b0;
			m_tdata   <= '0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_DONE) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == IW'(INIT_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						proc_q  <= in_proc;
						page_q  <= in_page;
						off_q   <= s_tdata[17:2];
						wr_q    <= s_tdata[34];
						acc_q   <= 1'b0;
						fault_q <= 1'b0;
						ev_q    <= 1'b0;
						evp_q   <= '0;
						evg_q   <= '0;
						wb_q    <= 1'b0;
						cnt_q   <= '0;
						if (proc_ok && s_tuser == OP_EXIT) begin
							state_q <= ST_EXS;
						end else if (proc_ok && page_ok && s_tuser == OP_ACCESS) begin
							acc_q   <= 1'b1;
							state_q <= ST_PRD;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_PRD: begin
					state_q <= ST_PCHK;
				end
				ST_PCHK: begin
					if (pm_rdata[FW]) begin
						f_q     <= pm_rdata[FW-1:0];
						state_q <= ST_HIT;
					end else begin
						fault_q <= 1'b1;
						if (faults_q != TOTAL_MAX) begin
							faults_q <= faults_q + 16'd1;
						end
						state_q <= ST_SCAN;
					end
				end
				ST_HIT: begin
					state_q <= ST_FIN;
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == FW'(FRAMES - 1)) begin
						state_q <= ST_SLAST;
					end
				end
				ST_SLAST: begin
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					f_q <= sel_f;
					if (!vic.free_found) begin
						ev_q  <= 1'b1;
						evp_q <= vic.best.owner;
						evg_q <= vic.best.page;
						wb_q  <= vic.best.dirty;
						if (vic.best.dirty && wbt_q != TOTAL_MAX) begin
							wbt_q <= wbt_q + 16'd1;
						end
					end
					state_q <= ST_ALLOC;
				end
				ST_ALLOC: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (next9 >= lim9) begin
						acc_cnt_q <= '0;
					end else begin
						acc_cnt_q <= next9[7:0];
					end
					state_q <= ST_DONE;
				end
				ST_EXS: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == FW'(FRAMES - 1)) begin
						state_q <= ST_EXL;
					end
				end
				ST_EXL: begin
					dead_q[proc_q] <= 1'b1;
					state_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= {3'b000, wbt_q, faults_q, wb_q, evg_q, evp_q, ev_q, fault_q,
							acc_q ? {8'(f_q), off_q} : 24'd0};
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_init_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT) |-> !s_tready)
		else $error("word taken during clearing pass");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted word did not start work");

	a_evict_fault: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[25] || m_tdata[24]))
		else $error("eviction without page fault");

	a_wb_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (!m_tdata[44] || m_tdata[25]))
		else $error("write-back without eviction");

endmodule
`default_nettype wire
